// ===== design/iate_pkg.sv =====
// Package: shared types and constants for the indexed array table engine.
package iate_pkg;
   localparam int DEPTH_DEF = 256;
   localparam int WORD_BITS_DEF = 32;
   localparam int IN_WORD_BITS = 32;
   localparam int POS_BITS = 8;
   localparam int CNT_BITS = 9;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0, OP_DELETE = 3'd1, OP_SEARCH = 3'd2,
      OP_UPDATE = 3'd3, OP_SORT = 3'd4, OP_PART = 3'd5,
      OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2,
      ST_BADIDX = 3'd3, ST_NOTFOUND = 3'd4
   } status_type;

   // memory port request from sequencer
   typedef struct packed {
      logic        rd_en;
      logic [11:0] rd_addr;
      logic        wr_en;
      logic [11:0] wr_addr;
      logic        wr_sel_hold;  // 1: write held word, 0: write read data
   } mem_ctl_type;
endpackage

// ===== design/iate_mem.sv =====
// Entry store: one write port, one registered read port.
module iate_mem #(
   parameter int DEPTH = iate_pkg::DEPTH_DEF,
   parameter int WORD_BITS = iate_pkg::WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]     rd_data
);
   import iate_pkg::*;
   logic [WORD_BITS-1:0] store_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= store_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ===== design/indexed_array_table_engine_unit.sv =====
// Top level: indexed array table engine with sequencer and one compare unit.
//
// Usage: a request transaction on req_ carries op, position and word. The
// block drops req_tready while it works; one response transaction on rsp_
// carries status, position and the new item count. A response waits in its
// output register while rsp_tready is low; the next request is taken once
// that register is free again (or emptying in the same cycle).
// Operation: insert and delete move one entry at a time, each a read then a
// write through the single memory port pair. Search reads one entry a cycle.
// Partition reads low words upward and high words downward, swapping a
// non-negative low word with a negative high word. Selection sort is
// quadratic: about count*count/2 compares, one compare a cycle in the
// signed comparator.
// Reset: count clears and capacity returns to 256; the store contents stay
// undefined, only entries below the count are ever read, so no clearing pass runs.
// The user must write capacity via csr_wr_en only when the block is idle (unchecked).
module indexed_array_table_engine_unit #(
   parameter int DEPTH = iate_pkg::DEPTH_DEF,
   parameter int WORD_BITS = iate_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // op[2:0], position_in[10:3], word_in[42:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], position_out[10:3], item_count[19:11]
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import iate_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_SRCH, S_SORT_RD, S_SORT_CMP,
      S_SORT_SW1, S_SORT_SW2, S_PART_RD, S_PART_CHK, S_PART_WR, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [8:0]           cap_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   op_type               op_ff, op_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [WORD_BITS-1:0] hold_ff, hold_in;   // min value / lo word
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in, m_ff, m_in;
   logic [CW:0]          hi_ff, hi_in;       // signed-ish: may reach -1
   logic                 rsp_v_ff, rsp_v_in;
   logic [2:0]           st_ff, st_in;
   logic [7:0]           po_ff, po_in;
   logic [CW-1:0]        last_addr_ff, last_addr_in; // address last read
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_wa, mem_ra;
   logic [WORD_BITS-1:0] mem_wd, mem_rd;
   logic                 less;                // signed comparator used by sort
   logic [WORD_BITS-1:0] cmp_a, cmp_b;

   logic [2:0]           f_op;
   logic [7:0]           f_pos;
   logic [31:0]          f_word;
   logic [WORD_BITS-1:0] w_in;
   logic [CW-1:0]        pos_ext, usable;
   logic                 accept;

   assign f_op   = req_tdata[2:0];
   assign f_pos  = req_tdata[10:3];
   assign f_word = req_tdata[42:11];
   assign w_in = WORD_BITS <= 32 ? WORD_BITS'(f_word)
                                 : WORD_BITS'({{32{f_word[31]}}, f_word});
   assign pos_ext = CW'(f_pos);
   assign usable = (32'(cap_ff) > DEPTH) ? CW'(DEPTH) : CW'(cap_ff);

   assign req_tready = (state_ff == S_IDLE) && (!rsp_v_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign less = $signed(cmp_a) < $signed(cmp_b);

   iate_mem #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_en(mem_re), .rd_addr(mem_ra), .rd_data(mem_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= 9'd256;
         cnt_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_v_ff <= rsp_v_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
      op_ff <= op_in; word_ff <= word_in; hold_ff <= hold_in;
      i_ff <= i_in; j_ff <= j_in; m_ff <= m_in; hi_ff <= hi_in;
      st_ff <= st_in; po_ff <= po_in; last_addr_ff <= last_addr_in;
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; op_in = op_ff; word_in = word_ff;
      hold_in = hold_ff; i_in = i_ff; j_in = j_ff; m_in = m_ff; hi_in = hi_ff;
      st_in = st_ff; po_in = po_ff; last_addr_in = last_addr_ff;
      rsp_v_in = rsp_v_ff && !rsp_tready;
      mem_we = 1'b0; mem_re = 1'b0; mem_wa = '0; mem_ra = '0; mem_wd = mem_rd;
      cmp_a = mem_rd; cmp_b = hold_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = op_type'(f_op); word_in = w_in; st_in = ST_OK; po_in = '0;
               state_in = S_DONE;
               unique case (op_type'(f_op))
                  OP_INSERT: begin
                     if (cnt_ff >= usable) st_in = ST_FULL;
                     else if (pos_ext > cnt_ff) st_in = ST_BADIDX;
                     else begin
                        i_in = cnt_ff; j_in = pos_ext; state_in = S_SHIFT_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (cnt_ff == '0) st_in = ST_EMPTY;
                     else if (pos_ext >= cnt_ff) st_in = ST_BADIDX;
                     else begin
                        i_in = pos_ext; state_in = S_SHIFT_RD;
                     end
                  end
                  OP_SEARCH: begin
                     st_in = ST_NOTFOUND; i_in = '0; state_in = S_SRCH;
                  end
                  OP_UPDATE: begin
                     if (pos_ext >= cnt_ff) st_in = ST_BADIDX;
                     else begin
                        mem_we = 1'b1; mem_wa = AW'(pos_ext); mem_wd = w_in;
                     end
                  end
                  OP_SORT: begin
                     i_in = '0; state_in = S_SORT_RD;
                  end
                  OP_PART: begin
                     i_in = '0; hi_in = (CW+1)'(cnt_ff) - 1'b1; state_in = S_PART_RD;
                  end
                  default: ;
               endcase
            end
         end
         // insert: i walks down from count to pos; delete: i walks up
         S_SHIFT_RD: begin
            if (op_ff == OP_INSERT) begin
               if (i_ff == j_ff) begin
                  mem_we = 1'b1; mem_wa = AW'(i_ff); mem_wd = word_ff;
                  cnt_in = cnt_ff + 1'b1; state_in = S_DONE;
               end else begin
                  mem_re = 1'b1; mem_ra = AW'(i_ff - 1'b1); state_in = S_SHIFT_WR;
               end
            end else begin
               if (i_ff + 1'b1 >= cnt_ff) begin
                  cnt_in = cnt_ff - 1'b1; state_in = S_DONE;
               end else begin
                  mem_re = 1'b1; mem_ra = AW'(i_ff + 1'b1); state_in = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            mem_we = 1'b1; mem_wa = AW'(i_ff); mem_wd = mem_rd;
            i_in = (op_ff == OP_INSERT) ? i_ff - 1'b1 : i_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end
         // search: issue read of i while checking data of i-1
         S_SRCH: begin
            if (i_ff != '0 && mem_rd == word_ff) begin
               st_in = ST_OK; po_in = 8'(i_ff - 1'b1); state_in = S_DONE;
            end else if (i_ff >= cnt_ff) begin
               state_in = S_DONE;
            end else begin
               mem_re = 1'b1; mem_ra = AW'(i_ff); i_in = i_ff + 1'b1;
            end
         end
         // sort pass: read a[i] as running min, scan j, swap m with i
         S_SORT_RD: begin
            if (i_ff >= cnt_ff) state_in = S_DONE;
            else begin
               mem_re = 1'b1; mem_ra = AW'(i_ff); m_in = i_ff;
               j_in = i_ff + 1'b1; last_addr_in = i_ff; state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            // mem_rd holds a[last_addr]
            if (last_addr_ff == i_ff) hold_in = mem_rd;
            else if (less) begin
               hold_in = mem_rd; m_in = last_addr_ff;
            end
            if (j_ff < cnt_ff) begin
               mem_re = 1'b1; mem_ra = AW'(j_ff); last_addr_in = j_ff;
               j_in = j_ff + 1'b1;
            end else begin
               mem_re = 1'b1; mem_ra = AW'(i_ff); state_in = S_SORT_SW1;
            end
         end
         S_SORT_SW1: begin
            // mem_rd = a[i]; write it to m
            mem_we = 1'b1; mem_wa = AW'(m_ff); mem_wd = mem_rd;
            state_in = S_SORT_SW2;
         end
         S_SORT_SW2: begin
            mem_we = 1'b1; mem_wa = AW'(i_ff); mem_wd = hold_ff;
            i_in = i_ff + 1'b1; state_in = S_SORT_RD;
         end
         // partition: i is lo; read lo then hi
         S_PART_RD: begin
            if ($signed(hi_ff) < $signed({1'b0, i_ff})) state_in = S_DONE;
            else begin
               mem_re = 1'b1; mem_ra = AW'(i_ff); j_in = '0; state_in = S_PART_CHK;
            end
         end
         S_PART_CHK: begin
            if (j_ff == '0) begin
               if (mem_rd[WORD_BITS-1]) begin
                  i_in = i_ff + 1'b1; state_in = S_PART_RD;
               end else begin
                  hold_in = mem_rd; j_in = CW'(1);
                  mem_re = 1'b1; mem_ra = AW'(hi_ff[CW-1:0]);
               end
            end else begin
               if (!mem_rd[WORD_BITS-1]) begin
                  // lo word stays non-negative; keep walking hi down
                  hi_in = hi_ff - 1'b1;
                  if ($signed(hi_ff - 1'b1) < $signed({1'b0, i_ff})) state_in = S_DONE;
                  else begin
                     mem_re = 1'b1; mem_ra = AW'(hi_ff - 1'b1);
                  end
               end else begin
                  mem_we = 1'b1; mem_wa = AW'(i_ff); mem_wd = mem_rd;
                  state_in = S_PART_WR;
               end
            end
         end
         S_PART_WR: begin
            mem_we = 1'b1; mem_wa = AW'(hi_ff[CW-1:0]); mem_wd = hold_ff;
            i_in = i_ff + 1'b1; hi_in = hi_ff - 1'b1; state_in = S_PART_RD;
         end
         S_DONE: begin
            rsp_v_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {4'd0, 9'(cnt_ff), po_ff, st_ff};

`ifndef SYNTHESIS
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= DEPTH) else $error("count above depth");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_v_ff) else $error("response lost");
   a_cnt_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> (cnt_ff == $past(cnt_ff)) || $past(state_ff) != S_IDLE)
      else $error("count moved while idle");
`endif
endmodule

// ===== tb/tb_indexed_array_table_engine_unit.sv =====
// Testbench: random and table-driven check of the indexed array table engine.
module tb_indexed_array_table_engine_unit;
   import iate_pkg::*;

   localparam int TBL_DEPTH = 256;

   // Clock, reset and block ports
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // op[2:0], position_in[10:3], word_in[42:11]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // status[2:0], position_out[10:3], item_count[19:11]
   logic        csr_wr_en;
   logic [8:0]  csr_wr_data;

   indexed_array_table_engine_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   typedef struct packed {
      status_type status;
      logic [7:0] position;
      logic [8:0] count;
   } table_reply_t;

   // Shadow copy of the table and its capacity register
   logic signed [31:0] shadow_words [TBL_DEPTH];
   int unsigned        shadow_count;
   int unsigned        shadow_capacity;

   table_reply_t reply_queue [$];
   int           error_total;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           recv_hold;      // long receiver hold-off in progress

   // Directed rows: an entry with has_reply set carries its expected reply
   typedef struct {
      op_type             op;
      logic [7:0]         pos;
      logic signed [31:0] word;
      bit                 has_reply;
      table_reply_t       reply;
   } table_row_t;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, well above the slowest legal run
   initial begin
      #(12 * 40_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   // Predicted reply for one request; updates the shadow table
   function automatic table_reply_t predict_table_op(op_type op, logic [7:0] pos,
                                                     logic signed [31:0] word);
      table_reply_t       r;
      int                 lo, hi, m, usable;
      logic signed [31:0] tmp;
      r.status   = ST_OK;
      r.position = '0;
      usable = (shadow_capacity > TBL_DEPTH) ? TBL_DEPTH : shadow_capacity;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= usable) r.status = ST_FULL;
            else if (pos > shadow_count) r.status = ST_BADIDX;
            else begin
               for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = word;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else if (pos >= shadow_count) r.status = ST_BADIDX;
            else begin
               for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
               shadow_count--;
            end
         end
         OP_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < shadow_count; i++)
               if (shadow_words[i] == word) begin
                  r.status   = ST_OK;
                  r.position = i[7:0];
                  break;
               end
         end
         OP_UPDATE: begin
            if (pos >= shadow_count) r.status = ST_BADIDX;
            else shadow_words[pos] = word;
         end
         OP_SORT: begin
            // selection sort, strict compare keeps the first minimum
            for (int i = 0; i < shadow_count; i++) begin
               m = i;
               for (int j = i + 1; j < shadow_count; j++)
                  if (shadow_words[m] > shadow_words[j]) m = j;
               tmp = shadow_words[m];
               shadow_words[m] = shadow_words[i];
               shadow_words[i] = tmp;
            end
         end
         OP_PART: begin
            lo = 0;
            hi = int'(shadow_count) - 1;
            while (lo <= hi) begin
               if (shadow_words[lo] < 0) lo++;
               else if (shadow_words[hi] >= 0) hi--;
               else begin
                  tmp = shadow_words[lo];
                  shadow_words[lo] = shadow_words[hi];
                  shadow_words[hi] = tmp;
                  lo++;
                  hi--;
               end
            end
         end
         default: ;
      endcase
      r.count = shadow_count[8:0];
      return r;
   endfunction

   // Offer one request; waits for the handshake, idling at random first
   task automatic send_request(op_type op, logic [7:0] pos, logic signed [31:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, word, pos, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reply_queue.push_back(predict_table_op(op, pos, word));
   endtask

   // Sender pause until every reply is back, plus latency slack
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (reply_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_capacity(int unsigned value);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[8:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_capacity = value;
      @(posedge clock);
   endtask

   // Random request, weighted toward inserts
   task automatic send_random(int unsigned max_pos);
      op_type             op;
      logic [7:0]         pos;
      logic signed [31:0] word;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 35) op = OP_INSERT;
      else if (pick < 55) op = OP_DELETE;
      else if (pick < 72) op = OP_SEARCH;
      else if (pick < 88) op = OP_UPDATE;
      else if (pick < 93) op = OP_SORT;
      else if (pick < 98) op = OP_PART;
      else op = op_type'($urandom_range(7, 6));
      // mostly legal indices, sometimes anything
      if ($urandom_range(9) == 0) pos = $urandom_range(255);
      else pos = $urandom_range(shadow_count < max_pos ? shadow_count : max_pos);
      // reuse stored words so searches hit often
      if (op == OP_SEARCH && shadow_count != 0 && $urandom_range(2) != 0)
         word = shadow_words[$urandom_range(shadow_count - 1)];
      else if ($urandom_range(3) == 0)
         word = $signed($urandom_range(15)) - 8;
      else
         word = $urandom;
      send_request(op, pos, word);
   endtask

   // Response checker
   always @(posedge clock) begin
      table_reply_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = status_type'(rsp_tdata[2:0]);
         got.position = rsp_tdata[10:3];
         got.count    = rsp_tdata[19:11];
         if (reply_queue.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            error_total++;
         end else begin
            want = reply_queue.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               error_total++;
            end
            if (got.position !== want.position) begin
               $display("%0t: position expected %0d actual %0d", $time, want.position,
                        got.position);
               error_total++;
            end
            if (got.count !== want.count) begin
               $display("%0t: item count expected %0d actual %0d", $time, want.count, got.count);
               error_total++;
            end
         end
      end
   end

   // Receiver back-pressure; recv_hold forces a long stall
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      table_row_t rows [$];
      table_reply_t r;
      error_total = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 32;
      recv_idle_pct = 73;
      recv_hold = 1'b0;
      shadow_count = 0;
      shadow_capacity = 256;
      foreach (shadow_words[i]) shadow_words[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table errors first, then extremes of word and index
      rows.push_back('{OP_DELETE, 8'd0, 0, 1, '{ST_EMPTY, 8'd0, 9'd0}});
      rows.push_back('{OP_UPDATE, 8'd0, 0, 1, '{ST_BADIDX, 8'd0, 9'd0}});
      rows.push_back('{OP_SEARCH, 8'd0, 0, 1, '{ST_NOTFOUND, 8'd0, 9'd0}});
      rows.push_back('{OP_SORT, 8'd0, 0, 1, '{ST_OK, 8'd0, 9'd0}});
      rows.push_back('{OP_PART, 8'd0, 0, 1, '{ST_OK, 8'd0, 9'd0}});
      rows.push_back('{OP_INSERT, 8'd255, 5, 1, '{ST_BADIDX, 8'd0, 9'd0}});
      rows.push_back('{OP_INSERT, 8'd0, 32'h7fffffff, 1, '{ST_OK, 8'd0, 9'd1}});
      rows.push_back('{OP_INSERT, 8'd0, 32'h80000000, 1, '{ST_OK, 8'd0, 9'd2}});
      rows.push_back('{OP_INSERT, 8'd2, -1, 0, r});
      rows.push_back('{OP_INSERT, 8'd1, 0, 0, r});
      rows.push_back('{OP_INSERT, 8'd4, 3, 0, r});
      rows.push_back('{OP_SEARCH, 8'd0, -1, 0, r});
      rows.push_back('{OP_SEARCH, 8'd0, 12345, 0, r});
      rows.push_back('{OP_PART, 8'd0, 0, 0, r});
      rows.push_back('{OP_SORT, 8'd0, 0, 0, r});
      rows.push_back('{OP_SEARCH, 8'd0, 32'h7fffffff, 0, r});
      rows.push_back('{OP_UPDATE, 8'd2, -7, 0, r});
      rows.push_back('{OP_UPDATE, 8'd5, 1, 0, r});
      rows.push_back('{OP_DELETE, 8'd255, 0, 0, r});
      rows.push_back('{OP_DELETE, 8'd4, 0, 0, r});
      rows.push_back('{OP_DELETE, 8'd0, 0, 0, r});
      rows.push_back('{OP_RSV6, 8'd255, -1, 0, r});
      rows.push_back('{OP_RSV7, 8'd0, 0, 0, r});
      foreach (rows[i]) begin
         send_request(rows[i].op, rows[i].pos, rows[i].word);
         if (rows[i].has_reply && reply_queue[$] != rows[i].reply) begin
            $display("%0t: table row %0d expected %h actual %h", $time, i, rows[i].reply,
                     reply_queue[$]);
            error_total++;
         end
      end

      // Capacity zero: every insert is full
      write_capacity(0);
      send_request(OP_INSERT, 8'd0, 1);
      // Capacity below the count keeps entries; inserts full until deleted below
      write_capacity(1);
      send_request(OP_INSERT, 8'd0, 2);
      send_request(OP_DELETE, 8'd0, 0);
      send_request(OP_DELETE, 8'd0, 0);
      send_request(OP_INSERT, 8'd0, 9);
      send_request(OP_INSERT, 8'd0, 9);
      // Above the array size acts as the full depth
      write_capacity(511);

      // Random phases: idling swaps, then none; capacity varies between phases
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_capacity(12);
            1: write_capacity(256);
            2: write_capacity(2);
            3: write_capacity($urandom_range(40, 3));
            4: write_capacity(300);
            default: write_capacity(20);
         endcase
         send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 73 : 0;
         recv_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 32 : 0;
         if (phase == 4) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  recv_hold = 1'b1;
                  repeat (400) @(posedge clock);
                  recv_hold = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 175; n++) begin
            // phase 1 builds a large table once; others stay small
            send_random(phase == 1 ? 255 : 24);
         end
      end
      // Fill the table once, then a full insert, a sort, a partition, a search and a delete
      drain_replies();
      write_capacity(256);
      while (shadow_count < 256) send_request(OP_INSERT, 8'($urandom_range(shadow_count)),
                                              $urandom);
      send_request(OP_INSERT, 8'd0, 0);
      send_request(OP_SORT, 8'd0, 0);
      send_request(OP_PART, 8'd0, 0);
      send_request(OP_SEARCH, 8'd0, shadow_words[255]);
      send_request(OP_DELETE, 8'd0, 0);

      drain_replies();
      if (error_total == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== files.f =====
design/iate_pkg.sv
design/iate_mem.sv
design/indexed_array_table_engine_unit.sv
tb/tb_indexed_array_table_engine_unit.sv
